[design/wheel_velocity_pid_macros.svh]
// Assertion macros shared by the wheel velocity PID checker.
// Depends on nothing; included by name where assertions are written.
`ifndef WHEEL_VELOCITY_PID_MACROS_SVH
`define WHEEL_VELOCITY_PID_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define WVP_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("wheel_velocity_pid: assertion failed");

// Next-cycle implication, disabled while reset is active
`define WVP_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("wheel_velocity_pid: assertion failed");

`endif

[design/wvp_pkg.sv]
// Shared constants and types for the wheel velocity PID controller.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package wvp_pkg;

    // Wheel channels and the width of a channel index
    localparam int NUM_WHEELS  = 2;
    localparam int WHEEL_IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_SPEED_SCALE   = 3'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [15:0] PROP_GAIN_RESET   = 16'd128;
    localparam logic [23:0] SPEED_SCALE_RESET = 24'd26808;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_HOLD = 2'd2;

    // Datapath widths
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 33;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int DIVD_W   = 40;
    localparam int ACC_W    = 51;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

endpackage

`default_nettype wire

[design/wheel_velocity_pid.sv]
// Top level of the wheel velocity PID controller: sequencer, shared
// multiplier, serial divider and per-wheel state. Depends on wvp_pkg.
`default_nettype none

// One request in, one result out, one request at a time. A regular sample
// passes from acceptance to the result register through one multiply of
// scale by count change, a 40-step restoring divider (one quotient bit per
// cycle) that turns it into speed, an error update, three gain multiplies
// through the same multiplier and a final rounding step. Restart and
// zero-elapsed-time requests go to S_FIN, which fills the result register
// unless output stalls. in_stall stays high while a request is in work;
// a finished result waits in the output register while the next is taken.
// Registers must be written by the user only between requests; unchecked.
module wheel_velocity_pid
    import wvp_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    // configuration write port
    input  wire                     cfg_we,
    input  wire [CFG_INDEX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire                     wheel,
    input  wire                     restart,
    input  wire [15:0]              encoder_count,
    input  wire [15:0]              elapsed_ms,
    input  wire signed [15:0]       target_speed,
    // result channel
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic                    wheel_out,
    output logic signed [15:0]      drive_power,
    output logic signed [15:0]      measured_speed,
    output logic [1:0]              status
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_SCALE   = 10'b00_0000_0010,
        S_DIVINIT = 10'b00_0000_0100,
        S_DIV     = 10'b00_0000_1000,
        S_ERR     = 10'b00_0001_0000,
        S_MUL_P   = 10'b00_0010_0000,
        S_MUL_I   = 10'b00_0100_0000,
        S_MUL_D   = 10'b00_1000_0000,
        S_ACC     = 10'b01_0000_0000,
        S_FIN     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] prop_gain_reg, integral_gain_reg, deriv_gain_reg;
    logic [23:0] speed_scale_reg;

    // per-wheel state
    logic [15:0]        last_count_reg  [NUM_WHEELS];
    logic signed [31:0] error_total_reg [NUM_WHEELS];
    logic signed [16:0] last_error_reg  [NUM_WHEELS];
    logic signed [15:0] power_level_reg [NUM_WHEELS];

    // captured request
    logic [WHEEL_IDX_W-1:0] idx_reg;
    logic                   wheel_reg, restart_reg, hold_reg;
    logic [15:0]            count_reg, ms_reg;
    logic signed [15:0]     target_reg;
    logic signed [16:0]     change_reg;

    // datapath
    logic signed [MUL_P_W-1:0] prod_reg;
    logic                      neg_reg;
    logic [DIVD_W-1:0]         quo_reg;
    logic [15:0]               rem_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic signed [15:0]        speed_reg;
    logic signed [16:0]        err_reg;
    logic signed [31:0]        sum_reg;
    logic signed [17:0]        delta_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      sat_reg;

    // output register
    logic                out_valid_reg, wheel_out_reg;
    logic signed [15:0]  drive_power_reg, measured_speed_reg;
    logic [1:0]          status_reg;

    logic                   in_fire, fin_fire;
    logic [WHEEL_IDX_W-1:0] in_idx;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [MUL_P_W-1:0] prod_mag;
    logic [16:0]        rem_sh;
    logic               rem_ge;

    logic               spd_sat;
    logic signed [15:0] spd;
    logic signed [16:0] err_c;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_c;
    logic               sum_sat;
    logic signed [17:0] delta_c;

    logic               pw_sat;
    logic signed [15:0] pw;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign fin_fire = (state_reg == S_FIN) && !(out_valid_reg && out_stall);
    assign in_idx   = WHEEL_IDX_W'(32'(wheel) % NUM_WHEELS);

    // Sequence the request through the shared units
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (restart || (elapsed_ms == 16'd0))
                        state_next = S_FIN;
                    else
                        state_next = S_SCALE;
                end
            end
            S_SCALE:   state_next = S_DIVINIT;
            S_DIVINIT: state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1))
                    state_next = S_ERR;
            end
            S_ERR:     state_next = S_MUL_P;
            S_MUL_P:   state_next = S_MUL_I;
            S_MUL_I:   state_next = S_MUL_D;
            S_MUL_D:   state_next = S_ACC;
            S_ACC:     state_next = S_FIN;
            S_FIN:
            begin
                if (fin_fire)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Select the shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SCALE:
            begin
                mul_a = $signed({1'b0, speed_scale_reg});
                mul_b = MUL_B_W'(change_reg);
            end
            S_MUL_P:
            begin
                mul_a = $signed({9'd0, prop_gain_reg});
                mul_b = MUL_B_W'(err_reg);
            end
            S_MUL_I:
            begin
                mul_a = $signed({9'd0, integral_gain_reg});
                mul_b = MUL_B_W'(sum_reg);
            end
            S_MUL_D:
            begin
                mul_a = $signed({9'd0, deriv_gain_reg});
                mul_b = MUL_B_W'(delta_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider step: one quotient bit per cycle
    assign prod_mag = prod_reg[MUL_P_W-1] ? MUL_P_W'(-prod_reg) : MUL_P_W'(prod_reg);
    assign rem_sh   = {rem_reg, quo_reg[DIVD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, ms_reg});

    // Saturate speed, form error, sum and error change
    always_comb
    begin
        spd_sat = 1'b0;
        spd     = '0;
        if (!neg_reg)
        begin
            if (quo_reg > DIVD_W'(32767))
            begin
                spd_sat = 1'b1;
                spd     = 16'sh7fff;
            end
            else
                spd = $signed(quo_reg[15:0]);
        end
        else
        begin
            if (quo_reg > DIVD_W'(32768))
            begin
                spd_sat = 1'b1;
                spd     = -16'sh8000;
            end
            else
                spd = $signed(16'(-quo_reg[15:0]));
        end
    end

    assign err_c    = 17'(target_reg) - 17'(spd);
    assign sum_wide = 33'(error_total_reg[idx_reg]) + 33'(err_c);
    assign sum_sat  = (sum_wide[32] != sum_wide[31]);
    assign sum_c    = sum_sat ? (sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                              : sum_wide[31:0];
    assign delta_c  = 18'(err_c) - 18'(last_error_reg[idx_reg]);

    // Round and saturate the new power
    always_comb
    begin
        pw_sat = (acc_reg[ACC_W-1:23] != {(ACC_W-23){acc_reg[23]}});
        if (pw_sat)
            pw = acc_reg[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
        else
            pw = acc_reg[23:8];
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RESET;
            integral_gain_reg <= '0;
            deriv_gain_reg    <= '0;
            speed_scale_reg   <= SPEED_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[15:0];
                REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data[15:0];
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[15:0];
                REG_SPEED_SCALE:   speed_scale_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Per-wheel state: clear on restart, update after a nonzero-time sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                last_count_reg[k]  <= '0;
                error_total_reg[k] <= '0;
                last_error_reg[k]  <= '0;
                power_level_reg[k] <= '0;
            end
        end
        else if (fin_fire && restart_reg)
        begin
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                last_count_reg[k]  <= '0;
                error_total_reg[k] <= '0;
                last_error_reg[k]  <= '0;
                power_level_reg[k] <= '0;
            end
        end
        else if (fin_fire && !hold_reg)
        begin
            last_count_reg[idx_reg]  <= count_reg;
            error_total_reg[idx_reg] <= sum_reg;
            last_error_reg[idx_reg]  <= err_reg;
            power_level_reg[idx_reg] <= pw;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_reg     <= in_idx;
                    wheel_reg   <= wheel;
                    restart_reg <= restart;
                    hold_reg    <= (elapsed_ms == 16'd0);
                    count_reg   <= encoder_count;
                    ms_reg      <= elapsed_ms;
                    target_reg  <= target_speed;
                    change_reg  <= $signed({1'b0, encoder_count})
                                 - $signed({1'b0, last_count_reg[in_idx]});
                end
            end
            S_SCALE:
                prod_reg <= mul_p;
            S_DIVINIT:
            begin
                neg_reg <= prod_reg[MUL_P_W-1];
                quo_reg <= prod_mag[DIVD_W-1:0];
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= rem_ge ? 16'(rem_sh - {1'b0, ms_reg}) : rem_sh[15:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_ERR:
            begin
                speed_reg <= spd;
                err_reg   <= err_c;
                sum_reg   <= sum_c;
                delta_reg <= delta_c;
                sat_reg   <= spd_sat || sum_sat;
                // held power in Q16.8 plus the rounding half
                acc_reg   <= $signed({{(ACC_W-24){power_level_reg[idx_reg][15]}},
                                      power_level_reg[idx_reg], 8'h80});
            end
            S_MUL_P:
                prod_reg <= mul_p;
            S_MUL_I, S_MUL_D:
            begin
                acc_reg  <= acc_reg + prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            S_ACC:
                acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            S_FIN:
                ;
            default:
                ;
        endcase
    end

    // Output request flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            wheel_out_reg <= wheel_reg;
            priority if (restart_reg)
            begin
                drive_power_reg    <= '0;
                measured_speed_reg <= '0;
                status_reg         <= STATUS_OK;
            end
            else if (hold_reg)
            begin
                drive_power_reg    <= power_level_reg[idx_reg];
                measured_speed_reg <= '0;
                status_reg         <= STATUS_HOLD;
            end
            else
            begin
                drive_power_reg    <= pw;
                measured_speed_reg <= speed_reg;
                status_reg         <= (sat_reg || pw_sat) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign wheel_out      = wheel_out_reg;
    assign drive_power    = drive_power_reg;
    assign measured_speed = measured_speed_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

[design/wvp_checker.sv]
// Port-level checker for the wheel velocity PID controller, bound to it.
// Depends on wvp_pkg and wheel_velocity_pid_macros.svh.
`default_nettype none

`include "wheel_velocity_pid_macros.svh"

module wvp_checker
    import wvp_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire [CFG_INDEX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data,
    input  wire                     in_valid,
    input  wire                     in_stall,
    input  wire                     wheel,
    input  wire                     restart,
    input  wire [15:0]              encoder_count,
    input  wire [15:0]              elapsed_ms,
    input  wire signed [15:0]       target_speed,
    input  wire                     out_valid,
    input  wire                     out_stall,
    input  wire                     wheel_out,
    input  wire signed [15:0]       drive_power,
    input  wire signed [15:0]       measured_speed,
    input  wire [1:0]               status
);

    // A stalled result stays put
    `WVP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(drive_power) && $stable(status))

    // One request in work at a time: busy right after acceptance
    `WVP_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

    // A held result reports no speed
    `WVP_ASSERT_IMP(a_hold_no_speed, clk, rst_n, out_valid && (status == STATUS_HOLD), measured_speed == 16'sd0)

    // An accepted restart is still off the output in the next cycle
    `WVP_ASSERT_NXT(a_restart_latency, clk, rst_n, in_valid && !in_stall && restart && !out_valid, !out_valid)

endmodule

bind wheel_velocity_pid wvp_checker u_wvp_checker (.*);

`default_nettype wire
